[design/pswg_pkg.sv]
// Shared types and constants for the per-source time window grouper.
// Holds the channel words, the front-to-back task word and the action codes.
// Depends on nothing.
`default_nettype none

package pswg_pkg;

   localparam int NUM_SOURCES_DEF = 8;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_IDX_W       = 4;
   localparam int CFG_W           = 16;
   localparam int COUNT_W         = 17;

   localparam logic [CFG_W-1:0] MAX_HITS_RST = 16'd960;
   localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HITS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 4'd1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

   typedef enum logic [2:0] {
      ACT_COMMIT = 3'd0,
      ACT_DROP   = 3'd1,
      ACT_OPEN   = 3'd2,
      ACT_APPEND = 3'd3,
      ACT_LATE   = 3'd4
   } action_type;

   typedef struct packed {
      logic [2:0]  source;
      logic [63:0] stamp;
      logic        has_hit;
      logic [63:0] hit_word;
   } req_type;

   typedef struct packed {
      action_type         action;
      logic [2:0]         out_source;
      logic [63:0]        out_stamp;
      logic [63:0]        out_word;
      logic [COUNT_W-1:0] event_hits;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] max_hits;
      logic [CFG_W-1:0] window_ticks;
   } cfg_type;

   // One classified item: up to three results, emitted close, open, append.
   typedef struct packed {
      logic [2:0]         source;
      logic               has_close;
      action_type         close_action;
      logic [63:0]        stamp_a;     // closed event start, late stamp, or current start
      logic [COUNT_W-1:0] close_hits;
      logic               has_open;
      logic [63:0]        stamp_b;     // start of the newly opened event
      logic               has_append;
      logic [63:0]        word;
   } task_type;

endpackage

`default_nettype wire

[design/pswg_front.sv]
// Front end of the grouper: accepts words, keeps per-source event state,
// classifies each word into a task for the back end.
// Depends on pswg_pkg.
`default_nettype none

module pswg_front #(
   parameter int NUM_SOURCES = pswg_pkg::NUM_SOURCES_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  pswg_pkg::cfg_type   cfg,
   input  wire                 req_valid,
   output logic                req_stall,
   input  pswg_pkg::req_type   req_data,
   input  wire                 queue_full,
   output logic                push,
   output pswg_pkg::task_type  push_data
);
   import pswg_pkg::*;

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   logic [63:0]        start_stamp_ff [NUM_SOURCES];
   logic [COUNT_W-1:0] hit_count_ff   [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] event_open_ff;
   logic [NUM_SOURCES-1:0] discarding_ff;

   logic [IDX_W-1:0]   idx;
   logic               accept, in_range, late, over, drop, begin_ev, commit, append;
   logic               open1, disc1, open2, disc2, update;
   logic [63:0]        st, diff, start_in;
   logic [COUNT_W-1:0] ct, ct1, ct2, count_in;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign idx       = IDX_W'(req_data.source);
   assign in_range  = 32'(req_data.source) < 32'(NUM_SOURCES);

   always_comb begin
      st    = start_stamp_ff[idx];
      ct    = hit_count_ff[idx];
      late  = req_data.stamp < st;
      over  = ct > COUNT_W'(cfg.max_hits);
      drop  = over & event_open_ff[idx];
      open1 = event_open_ff[idx] & ~over;
      disc1 = discarding_ff[idx] | drop;
      ct1   = over ? '0 : ct;
      diff  = req_data.stamp - st;
      begin_ev = (diff > 64'(cfg.window_ticks)) || (req_data.stamp == 64'd0) ||
                 (!open1 && !disc1);
      commit   = begin_ev & open1;
      start_in = begin_ev ? req_data.stamp : st;
      ct2      = begin_ev ? '0 : ct1;
      open2    = begin_ev | open1;
      disc2    = begin_ev ? 1'b0 : disc1;
      append   = req_data.has_hit & ~disc2 & open2;
      count_in = (append && ct2 != COUNT_MAX) ? ct2 + 1'b1 : ct2;
      update   = accept & in_range & ~late;
   end

   always_comb begin
      push_data.source       = req_data.source;
      push_data.has_close    = late | drop | commit;
      push_data.close_action = late ? ACT_LATE : (drop ? ACT_DROP : ACT_COMMIT);
      push_data.stamp_a      = late ? req_data.stamp : st;
      push_data.close_hits   = late ? '0 : ct;
      push_data.has_open     = ~late & begin_ev;
      push_data.stamp_b      = req_data.stamp;
      push_data.has_append   = ~late & append;
      push_data.word         = req_data.hit_word;
      push = accept & in_range & (late | drop | commit | begin_ev | append);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            start_stamp_ff[i] <= '0;
            hit_count_ff[i]   <= '0;
         end
         event_open_ff <= '0;
         discarding_ff <= '0;
      end else if (update) begin
         start_stamp_ff[idx] <= start_in;
         hit_count_ff[idx]   <= count_in;
         event_open_ff[idx]  <= open2;
         discarding_ff[idx]  <= disc2;
      end
   end

endmodule

`default_nettype wire

[design/pswg_queue.sv]
// Short task queue between the grouper front end and back end.
// Flop-based ring of QUEUE_DEPTH task words; depends on pswg_pkg.
`default_nettype none

module pswg_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  pswg_pkg::task_type  push_data,
   output logic                full,
   input  wire                 pop,
   output logic                not_empty,
   output pswg_pkg::task_type  head
);
   import pswg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   task_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/pswg_back.sv]
// Back end of the grouper: walks the head task's results in order
// (close, open, append) into a registered output word. Depends on pswg_pkg.
`default_nettype none

module pswg_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 head_valid,
   input  pswg_pkg::task_type  head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output pswg_pkg::rsp_type   rsp_data
);
   import pswg_pkg::*;

   logic [2:0] done_ff, done_in, pend, sel, rem;
   logic       rsp_valid_ff, rsp_valid_in, out_free, emit, last;
   rsp_type    rsp_data_ff, rsp_data_in;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      pend = {head.has_append, head.has_open, head.has_close} & ~done_ff;
      sel  = pend & (~pend + 1'b1);   // lowest pending result
      rem  = pend & ~sel;
      last = rem == 3'b000;
      emit = head_valid & out_free;
      pop  = emit & last;
      done_in = done_ff;
      if (emit) begin
         done_in = last ? 3'b000 : (done_ff | sel);
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_comb begin
      rsp_data_in.out_source = head.source;
      rsp_data_in.last       = last;
      rsp_data_in.out_word   = '0;
      rsp_data_in.event_hits = '0;
      case (sel)
         3'b001: begin
            rsp_data_in.action     = head.close_action;
            rsp_data_in.out_stamp  = head.stamp_a;
            rsp_data_in.event_hits = head.close_hits;
         end
         3'b010: begin
            rsp_data_in.action    = ACT_OPEN;
            rsp_data_in.out_stamp = head.stamp_b;
         end
         default: begin
            rsp_data_in.action    = ACT_APPEND;
            rsp_data_in.out_stamp = head.has_open ? head.stamp_b : head.stamp_a;
            rsp_data_in.out_word  = head.word;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

[design/per_source_time_window_grouper_top.sv]
// Per-source time window grouper: top level with configuration registers.
// Instantiates pswg_front, pswg_queue and pswg_back; depends on pswg_pkg.
//
// Usage:
//   req_* carries timestamped hits and trigger markers tagged by source;
//   a word is taken when req_valid is high and req_stall is low.
//   rsp_* delivers commit/drop/open/append/late words, one per cycle when
//   rsp_stall is low, with last set on the final word caused by an input word.
//   csr_* writes max_hits (index 0) and window_ticks (index 1); csr_ready
//   is always high and other indexes are ignored. Write only while idle.
// Timing:
//   the front end updates per-source state on acceptance, so it takes one
//   word per cycle while req_stall is low. Results pass through the task
//   queue and then the output register, one at a time; a four-entry task
//   queue absorbs bursts, and req_stall rises when it fills. When rsp_stall
//   is high the output word holds and the queue backs up.
// Reset: clears all per-source state (no event open), empties the queue,
//   and loads max_hits = 960, window_ticks = 2.
`default_nettype none

module per_source_time_window_grouper_top #(
   parameter int NUM_SOURCES = pswg_pkg::NUM_SOURCES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  pswg_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output pswg_pkg::rsp_type                rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [pswg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [pswg_pkg::CFG_W-1:0]       csr_data
);
   import pswg_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   task_type push_data, head;
   logic     push, pop, queue_full, not_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_HITS: cfg_in.max_hits     = csr_data;
            CSR_WINDOW:   cfg_in.window_ticks = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_hits     <= MAX_HITS_RST;
         cfg_ff.window_ticks <= WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pswg_front #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   pswg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   pswg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for per_source_time_window_grouper_top.
// Predicts the commit/drop/open/append/late words per source in a small
// scoreboard class; depends on pswg_pkg and the design top only.
`default_nettype none

module testbench;
   import pswg_pkg::*;

   localparam int SOURCES     = NUM_SOURCES_DEF;
   localparam int TAIL_CYCLES = 16;
   localparam int PHASE_ITEMS = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP   = 4'd15;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   bit          quiet;
   logic [63:0] trail [SOURCES];

   per_source_time_window_grouper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   class event_scoreboard;
      logic [CFG_W-1:0]   max_hits;
      logic [CFG_W-1:0]   window_ticks;
      logic [63:0]        start_stamp [SOURCES];
      logic [COUNT_W-1:0] hit_count [SOURCES];
      bit                 event_open [SOURCES];
      bit                 discarding [SOURCES];
      rsp_type            expected_actions [$];
      int                 mismatches;

      function new();
         max_hits     = MAX_HITS_RST;
         window_ticks = WINDOW_RST;
         for (int i = 0; i < SOURCES; i++) begin
            start_stamp[i] = '0;
            hit_count[i]   = '0;
            event_open[i]  = 1'b0;
            discarding[i]  = 1'b0;
         end
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_MAX_HITS: max_hits = value;
            CSR_WINDOW:   window_ticks = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_actions.size();
      endfunction

      function rsp_type make_action(action_type act, logic [2:0] src, logic [63:0] stamp,
                                    logic [63:0] word, logic [COUNT_W-1:0] hits);
         rsp_type a;
         a.action     = act;
         a.out_source = src;
         a.out_stamp  = stamp;
         a.out_word   = word;
         a.event_hits = hits;
         a.last       = 1'b0;
         return a;
      endfunction

      function void note_input(req_type r);
         rsp_type     acts [3];
         int          n;
         logic [2:0]  s;
         logic [63:0] gap;
         bit          opening;
         n = 0;
         s = r.source;
         if (int'(s) >= SOURCES) return;
         if (r.stamp < start_stamp[s]) begin
            // late word: report it, leave state alone
            acts[0] = make_action(ACT_LATE, s, r.stamp, '0, '0);
            n = 1;
         end else begin
            if (hit_count[s] > {1'b0, max_hits}) begin
               if (event_open[s]) begin
                  acts[n] = make_action(ACT_DROP, s, start_stamp[s], '0, hit_count[s]);
                  n++;
                  event_open[s] = 1'b0;
                  discarding[s] = 1'b1;
               end
               hit_count[s] = '0;
            end
            gap = r.stamp - start_stamp[s];
            opening = (gap > {48'd0, window_ticks}) || (r.stamp == '0) ||
                      (!event_open[s] && !discarding[s]);
            if (opening) begin
               if (event_open[s]) begin
                  acts[n] = make_action(ACT_COMMIT, s, start_stamp[s], '0, hit_count[s]);
                  n++;
               end
               acts[n] = make_action(ACT_OPEN, s, r.stamp, '0, '0);
               n++;
               start_stamp[s] = r.stamp;
               hit_count[s]   = '0;
               event_open[s]  = 1'b1;
               discarding[s]  = 1'b0;
            end
            if (r.has_hit && !discarding[s] && event_open[s]) begin
               acts[n] = make_action(ACT_APPEND, s, start_stamp[s], r.hit_word, '0);
               n++;
               if (hit_count[s] < COUNT_MAX) hit_count[s]++;
            end
         end
         if (n > 0) acts[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) expected_actions.push_back(acts[i]);
      endfunction

      task report_mismatch(string what);
         $display("%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_actions.size() == 0) begin
            report_mismatch("result word with nothing expected");
            return;
         end
         want = expected_actions.pop_front();
         if (got.action !== want.action)
            report_mismatch($sformatf("action got %0d want %0d", got.action, want.action));
         if (got.out_source !== want.out_source)
            report_mismatch($sformatf("source got %0d want %0d",
                                      got.out_source, want.out_source));
         if (got.out_stamp !== want.out_stamp)
            report_mismatch($sformatf("stamp got %h want %h", got.out_stamp, want.out_stamp));
         if (got.out_word !== want.out_word)
            report_mismatch($sformatf("word got %h want %h", got.out_word, want.out_word));
         if (got.event_hits !== want.event_hits)
            report_mismatch($sformatf("event_hits got %0d want %0d",
                                      got.event_hits, want.event_hits));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %b want %b", got.last, want.last));
      endtask
   endclass

   event_scoreboard board = new();

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("per_source_time_window_grouper_top: mismatch");
      $finish;
   end

   function automatic int pause();
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic req_type mk(logic [2:0] src, logic [63:0] stamp, logic hit,
                                  logic [63:0] word);
      req_type r;
      r.source   = src;
      r.stamp    = stamp;
      r.has_hit  = hit;
      r.hit_word = word;
      return r;
   endfunction

   // Mostly creeping per-source stamps, with jumps, zeros, late and wild stamps mixed in.
   function automatic req_type make_item();
      req_type     r;
      int          pick;
      logic [2:0]  s;
      logic [63:0] stamp;
      s = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         stamp = trail[s] + 64'($urandom_range(0, 3));
         trail[s] = stamp;
      end else if (pick < 75) begin
         stamp = trail[s] + 64'($urandom_range(1, 70000));
         trail[s] = stamp;
      end else if (pick < 83) begin
         stamp = '0;
         trail[s] = stamp;
      end else if (pick < 91) begin
         stamp = trail[s] - 64'($urandom_range(1, 4));
      end else begin
         stamp = {$urandom, $urandom};
         trail[s] = stamp;
      end
      r = mk(s, stamp, $urandom_range(0, 3) != 0, {$urandom, $urandom});
      return r;
   endfunction

   task automatic send_item(req_type r);
      int gap;
      gap = pause();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_input(r);
   endtask

   // Drop valid, wait out every expected word, then let the pipe empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
         send_item(make_item());
      end
      quiet = 1'b0;
   endtask

   // Result side: random stall before each word, check at the accepting edge.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold = pause();
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         board.check_result(rsp_data);
      end
   end

   initial begin
      logic [CFG_W-1:0] cfg_max [6];
      logic [CFG_W-1:0] cfg_win [6];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      quiet     = 1'b0;
      for (int i = 0; i < SOURCES; i++) trail[i] = {$urandom, $urandom};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset configuration: window of two ticks
      send_item(mk(3'd0, 64'd0, 1'b0, 64'd0));
      send_item(mk(3'd0, 64'd1, 1'b1, '1));
      send_item(mk(3'd0, 64'd2, 1'b0, 64'd0));
      send_item(mk(3'd0, 64'd3, 1'b1, 64'h0123_4567_89ab_cdef));
      send_item(mk(3'd0, 64'd2, 1'b1, 64'h5555_5555_5555_5555));
      send_item(mk(3'd7, '1, 1'b1, 64'd0));
      send_item(mk(3'd7, 64'd0, 1'b1, '1));
      send_item(mk(3'd1, 64'd0, 1'b1, 64'haaaa_aaaa_aaaa_aaaa));
      send_item(mk(3'd1, 64'd0, 1'b0, 64'd0));
      send_item(mk(3'd6, 64'h8000_0000_0000_0000, 1'b0, 64'd0));
      settle();

      // drop after a single hit, widest window; spare indexes must be ignored
      write_csr(CSR_MAX_HITS, 16'd0);
      write_csr(CSR_WINDOW, 16'hffff);
      write_csr(CSR_SPARE, 16'h1234);
      write_csr(CSR_TOP, 16'hffff);
      send_item(mk(3'd2, 64'd100, 1'b1, 64'h1111_2222_3333_4444));
      send_item(mk(3'd2, 64'd101, 1'b1, 64'h2222_3333_4444_5555));
      send_item(mk(3'd2, 64'd102, 1'b1, 64'h3333_4444_5555_6666));
      send_item(mk(3'd2, 64'd50, 1'b1, 64'h4444_5555_6666_7777));
      send_item(mk(3'd2, 64'd65636, 1'b0, 64'd0));
      send_item(mk(3'd2, 64'd131171, 1'b1, 64'hffff_0000_ffff_0000));
      send_item(mk(3'd2, 64'd131171, 1'b0, 64'd0));
      send_item(mk(3'd3, 64'd0, 1'b1, 64'h0f0f_0f0f_0f0f_0f0f));
      send_item(mk(3'd3, 64'd0, 1'b1, 64'hf0f0_f0f0_f0f0_f0f0));
      settle();

      // largest limit, zero window
      write_csr(CSR_MAX_HITS, 16'hffff);
      write_csr(CSR_WINDOW, 16'd0);
      send_item(mk(3'd4, 64'd5, 1'b1, 64'd1));
      send_item(mk(3'd4, 64'd5, 1'b1, 64'd2));
      send_item(mk(3'd4, 64'd6, 1'b1, 64'd3));
      send_item(mk(3'd5, '1, 1'b1, '1));
      send_item(mk(3'd5, '1, 1'b0, 64'd0));
      settle();

      cfg_max = '{16'd3, 16'd0, 16'hffff, 16'd2, 16'($urandom_range(0, 8)), 16'd1};
      cfg_win = '{16'd2, 16'd0, 16'hffff, 16'd5, 16'($urandom), 16'd1};
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_MAX_HITS, cfg_max[p]);
         write_csr(CSR_WINDOW, cfg_win[p]);
         run_random(PHASE_ITEMS);
         settle();
      end

      if (board.pending() != 0) board.report_mismatch("expected words left over");
      if (board.mismatches == 0) begin
         $display("per_source_time_window_grouper_top: match");
      end else begin
         $display("per_source_time_window_grouper_top: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
